// ----- rtl/emavg_pkg.sv -----
package emavg_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int USED_W     = 7;
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_LENGTH = CFG_IDX_W'(1);

    localparam logic [USED_W-1:0] WINDOW_RESET = USED_W'(1);
    localparam int                LENGTH_RESET = 4096;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

// ----- rtl/emavg_if.sv -----
interface emavg_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [emavg_pkg::SAMPLE_W-1:0]    sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface emavg_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [emavg_pkg::SAMPLE_W-1:0]    average_value;
    logic        [emavg_pkg::USED_W-1:0]      epochs_used;
    logic                                     epoch_end;

    modport source (output valid, output average_value, output epochs_used,
                    output epoch_end, input ready);
    modport sink   (input valid, input average_value, input epochs_used,
                    input epoch_end, output ready);
endinterface

interface emavg_cfg_if;
    logic                                     valid;
    logic                                     ready;
    logic [emavg_pkg::CFG_IDX_W-1:0]          reg_index;
    logic [emavg_pkg::CFG_DATA_W-1:0]         wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/emavg_div.sv -----
module emavg_div #(
    parameter int SUM_W = 30
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [SUM_W-1:0]               dividend,
    input  logic        [emavg_pkg::USED_W-1:0]   divisor,
    output logic signed [emavg_pkg::SAMPLE_W-1:0] quotient,
    output logic                                  done
);

    localparam int CNT_W = $clog2(SUM_W + 1);
    localparam int DW    = emavg_pkg::USED_W;
    localparam int QW    = emavg_pkg::SAMPLE_W;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] q_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dvs_reg;
    logic             neg_reg;

    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;
    logic [DW-1:0]    rem_next;
    logic [QW-1:0]    mag;

    // restoring division, one quotient bit per cycle
    assign trial    = {rem_reg, q_reg[SUM_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign mag      = q_reg[QW-1:0];
    assign quotient = neg_reg ? $signed(~mag + QW'(1)) : $signed(mag);
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[SUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

endmodule

// ----- rtl/emavg_datapath.sv -----
module emavg_datapath #(
    parameter int MAX_EPOCHS    = 64,
    parameter int MAX_POSITIONS = 4096
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  emavg_pkg::cmd_t                         cmd,
    output emavg_pkg::status_t                      status,
    input  logic signed [emavg_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic                                    cfg_wr,
    input  logic        [emavg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [emavg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic signed [emavg_pkg::SAMPLE_W-1:0]   average_value,
    output logic        [emavg_pkg::USED_W-1:0]     epochs_used,
    output logic                                    epoch_end
);

    localparam int SW     = emavg_pkg::SAMPLE_W;
    localparam int UW     = emavg_pkg::USED_W;
    localparam int LW     = emavg_pkg::LEN_W;
    localparam int SUM_W  = SW + $clog2(MAX_EPOCHS);
    localparam int DEPTH  = MAX_EPOCHS * MAX_POSITIONS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int SLOT_W = (MAX_EPOCHS > 1) ? $clog2(MAX_EPOCHS) : 1;
    localparam logic [LW-1:0] LEN_INIT =
        LW'((MAX_POSITIONS < emavg_pkg::LENGTH_RESET) ? MAX_POSITIONS
                                                      : emavg_pkg::LENGTH_RESET);

    logic signed [SUM_W-1:0] sums_mem [MAX_POSITIONS];
    logic signed [SW-1:0]    store_mem [DEPTH];

    logic [UW-1:0]           window_reg;
    logic [LW-1:0]           length_reg;
    logic [UW-1:0]           seen_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [ADDR_W-1:0]       base_reg;
    logic [POS_W-1:0]        pos_reg;

    logic signed [SW-1:0]    sample_reg;
    logic signed [SUM_W-1:0] sum_rd_reg;
    logic signed [SW-1:0]    store_rd_reg;
    logic [UW-1:0]           used_reg;
    logic                    last_reg;
    logic signed [SW-1:0]    avg_out_reg;
    logic [UW-1:0]           used_out_reg;
    logic                    end_out_reg;

    logic [ADDR_W-1:0]       store_addr;
    logic                    full;
    logic [UW-1:0]           used;
    logic                    last;
    logic [8:0]              slot_inc;
    logic                    slot_wrap;
    logic signed [SUM_W-1:0] old_sum;
    logic signed [SUM_W-1:0] old_sample;
    logic signed [SUM_W-1:0] new_sum;
    logic [UW-1:0]           win_clamp;
    logic [LW-1:0]           len_clamp;
    logic signed [SW-1:0]    quotient;
    logic                    div_done;

    assign store_addr = base_reg + ADDR_W'(pos_reg);
    assign full       = seen_reg >= window_reg;
    assign used       = full ? window_reg : seen_reg + UW'(1);
    assign last       = (32'(pos_reg) + 32'd1) >= 32'(length_reg);
    assign slot_inc   = 9'(slot_reg) + 9'd1;
    assign slot_wrap  = slot_inc >= 9'(window_reg);

    // nothing is trusted in the sum memory until the first epoch has written it
    assign old_sum    = (seen_reg == '0) ? '0 : sum_rd_reg;
    assign old_sample = full ? SUM_W'(store_rd_reg) : '0;
    assign new_sum    = old_sum - old_sample + SUM_W'(sample_reg);

    always_comb
    begin
        if (cfg_wdata[UW-1:0] == '0)
            win_clamp = UW'(1);
        else if (32'(cfg_wdata[UW-1:0]) > MAX_EPOCHS)
            win_clamp = UW'(MAX_EPOCHS);
        else
            win_clamp = cfg_wdata[UW-1:0];

        if (cfg_wdata[LW-1:0] == '0)
            len_clamp = LW'(1);
        else if (32'(cfg_wdata[LW-1:0]) > MAX_POSITIONS)
            len_clamp = LW'(MAX_POSITIONS);
        else
            len_clamp = cfg_wdata[LW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= emavg_pkg::WINDOW_RESET;
            length_reg <= LEN_INIT;
            seen_reg   <= '0;
            slot_reg   <= '0;
            base_reg   <= '0;
            pos_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                emavg_pkg::REG_WINDOW_SIZE:
                begin
                    window_reg <= win_clamp;
                    seen_reg   <= '0;
                    slot_reg   <= '0;
                    base_reg   <= '0;
                    pos_reg    <= '0;
                end
                emavg_pkg::REG_EPOCH_LENGTH:
                begin
                    length_reg <= len_clamp;
                    seen_reg   <= '0;
                    slot_reg   <= '0;
                    base_reg   <= '0;
                    pos_reg    <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.update)
        begin
            if (last)
            begin
                pos_reg <= '0;
                if (slot_wrap)
                begin
                    slot_reg <= '0;
                    base_reg <= '0;
                end
                else
                begin
                    slot_reg <= SLOT_W'(slot_inc);
                    base_reg <= base_reg + ADDR_W'(MAX_POSITIONS);
                end
                if (!full)
                    seen_reg <= seen_reg + UW'(1);
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg   <= sample_in;
            sum_rd_reg   <= sums_mem[pos_reg];
            store_rd_reg <= store_mem[store_addr];
        end
        if (cmd.update)
        begin
            sums_mem[pos_reg]     <= new_sum;
            store_mem[store_addr] <= sample_reg;
            used_reg              <= used;
            last_reg              <= last;
        end
        if (cmd.load_out)
        begin
            avg_out_reg  <= quotient;
            used_out_reg <= used_reg;
            end_out_reg  <= last_reg;
        end
    end

    emavg_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.update),
        .dividend (new_sum),
        .divisor  (used),
        .quotient (quotient),
        .done     (div_done)
    );

    assign status.div_done = div_done;
    assign average_value   = avg_out_reg;
    assign epochs_used     = used_out_reg;
    assign epoch_end       = end_out_reg;

endmodule

// ----- rtl/emavg_ctrl.sv -----
module emavg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  emavg_pkg::status_t   status,
    output emavg_pkg::cmd_t      cmd
);

    emavg_pkg::state_t state_reg;
    emavg_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= emavg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            emavg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = emavg_pkg::ST_UPDATE;
                end
            end
            emavg_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = emavg_pkg::ST_DIV;
            end
            emavg_pkg::ST_DIV:
            begin
                // hold the quotient until the output register frees up
                if (status.div_done && (!out_valid_reg || out_ready))
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = emavg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = emavg_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/epoch_moving_average_unit.sv -----
// Moving epoch average. Signed 24-bit samples arrive one per item on in_stream,
// grouped into epochs of epoch_length samples; each sample yields one item on
// out_stream holding the truncated average at that sample position over the
// last min(window_size, epochs seen) epochs, the current one included. One
// item is processed at a time. The sum and epoch memories are read in the
// cycle the sample is accepted; then an update state writes them and starts
// the bit-serial divider on a sum of SUM_W = 24 + log2(MAX_EPOCHS) bits. Once
// the divider is done and the output register is free, a final state loads
// that register; only then is a new sample taken, so the divider and the
// output side set the rate. A finished result sits in an output register, so
// the next sample is taken while it waits.
// Writing either register clears the history; no clearing pass is needed, as
// sum memory contents are ignored until the first epoch has rewritten them.
// cfg.ready is always high; registers must be written only while the block is idle (the block does not enforce it).
module epoch_moving_average_unit #(
    parameter int MAX_EPOCHS    = 64,
    parameter int MAX_POSITIONS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    emavg_in_if.sink    in_stream,
    emavg_out_if.source out_stream,
    emavg_cfg_if.sink   cfg
);

    emavg_pkg::cmd_t    cmd;
    emavg_pkg::status_t status;

    assign cfg.ready = 1'b1;

    emavg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_stream.valid),
        .in_ready  (in_stream.ready),
        .out_valid (out_stream.valid),
        .out_ready (out_stream.ready),
        .status    (status),
        .cmd       (cmd)
    );

    emavg_datapath #(
        .MAX_EPOCHS    (MAX_EPOCHS),
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample_in     (in_stream.sample_value),
        .cfg_wr        (cfg.valid),
        .cfg_index     (cfg.reg_index),
        .cfg_wdata     (cfg.wdata),
        .average_value (out_stream.average_value),
        .epochs_used   (out_stream.epochs_used),
        .epoch_end     (out_stream.epoch_end)
    );

endmodule

// ----- rtl/emavg_checker.sv -----
module emavg_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [emavg_pkg::SAMPLE_W-1:0] average_value,
    input logic        [emavg_pkg::USED_W-1:0]   epochs_used,
    input logic                                  epoch_end
);

    // one item in flight: no acceptance right after another
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous item in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (epochs_used != '0))
        else $error("result with zero epochs");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##1 !(in_valid && in_ready))
        else $error("input accepted before update finished");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(average_value) && $stable(epochs_used)
             && $stable(epoch_end)))
        else $error("stalled result changed");

endmodule

bind epoch_moving_average_unit emavg_checker u_emavg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_stream.valid),
    .in_ready      (in_stream.ready),
    .out_valid     (out_stream.valid),
    .out_ready     (out_stream.ready),
    .average_value (out_stream.average_value),
    .epochs_used   (out_stream.epochs_used),
    .epoch_end     (out_stream.epoch_end)
);

// ----- bench/tb_epoch_moving_average_unit.sv -----
module tb_epoch_moving_average_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W   = emavg_pkg::SAMPLE_W;
    localparam int USED_W     = emavg_pkg::USED_W;
    localparam int CFG_IDX_W  = emavg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = emavg_pkg::CFG_DATA_W;

    localparam int EPOCH_SLOTS    = 64;
    localparam int POSITION_SLOTS = 4096;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(9);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    typedef enum int {
        MIX_ANY,
        MIX_HIGH,
        MIX_LOW
    } sample_mix_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] avg;
        logic        [USED_W-1:0]   used;
        logic                       last;
    } avg_result_t;

    logic clk;
    logic rst_n;

    emavg_in_if  in_if();
    emavg_out_if out_if();
    emavg_cfg_if cfg_if();

    epoch_moving_average_unit #(
        .MAX_EPOCHS    (EPOCH_SLOTS),
        .MAX_POSITIONS (POSITION_SLOTS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg        (cfg_if)
    );

    // shadow of the averaging state
    int unsigned window_eff;
    int unsigned length_eff;
    int unsigned slot_ptr;
    int unsigned epochs_done;
    int unsigned position_ptr;
    longint      column_sum [POSITION_SLOTS];
    int          epoch_history [int];

    logic signed [SAMPLE_W-1:0] pending_samples [$];
    avg_result_t                avg_expected [$];

    int mismatch_count;
    int results_seen;
    int settings_count;
    int peak_used;
    int in_idle_pct;
    int out_idle_pct;
    int in_gap;
    int hold_left;
    int long_hold_mark;
    bit long_hold_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned bound_setting(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_history();
        foreach (column_sum[i]) column_sum[i] = 0;
        slot_ptr     = 0;
        epochs_done  = 0;
        position_ptr = 0;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        if (idx == emavg_pkg::REG_WINDOW_SIZE) begin
            window_eff = bound_setting(int'(data[USED_W-1:0]), EPOCH_SLOTS);
            clear_history();
        end else if (idx == emavg_pkg::REG_EPOCH_LENGTH) begin
            length_eff = bound_setting(int'(data), POSITION_SLOTS);
            clear_history();
        end
    endfunction

    function automatic void predict_average(logic signed [SAMPLE_W-1:0] s);
        int unsigned hist_key;
        int unsigned used;
        longint      quotient;
        avg_result_t r;
        hist_key = slot_ptr * POSITION_SLOTS + position_ptr;
        if (epochs_done >= window_eff)
            column_sum[position_ptr] -= longint'(epoch_history[hist_key]);
        column_sum[position_ptr] += longint'(s);
        epoch_history[hist_key] = int'(s);
        used = (epochs_done + 1 > window_eff) ? window_eff : epochs_done + 1;
        quotient = column_sum[position_ptr] / longint'(used);
        r.avg  = quotient[SAMPLE_W-1:0];
        r.used = used[USED_W-1:0];
        r.last = (position_ptr + 1 >= length_eff);
        avg_expected.push_back(r);
        if (r.last) begin
            position_ptr = 0;
            slot_ptr     = (slot_ptr + 1) % window_eff;
            if (epochs_done < window_eff) epochs_done++;
        end else begin
            position_ptr++;
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_mix_t mix);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (mix == MIX_HIGH && roll != 0) return SAMPLE_MAX;
        if (mix == MIX_LOW && roll != 0) return SAMPLE_MIN;
        case (roll)
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'($signed($urandom_range(0, 32)) - 16);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // sender
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            in_gap      <= 0;
        end else begin
            if (in_if.valid && in_if.ready) predict_average(in_if.sample_value);
            if (!in_if.valid || in_if.ready) begin
                if (in_gap != 0) begin
                    in_gap      <= in_gap - 1;
                    in_if.valid <= 1'b0;
                end else if (pending_samples.size() != 0 && in_idle_pct != 0
                             && $urandom_range(0, 99) < in_idle_pct) begin
                    in_gap      <= $urandom_range(0, 9);
                    in_if.valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    in_if.valid        <= 1'b1;
                    in_if.sample_value <= pending_samples.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk) begin
        avg_result_t want;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (avg_expected.size() == 0) begin
                    flag_mismatch($sformatf("item %0d arrived with nothing pending",
                                            results_seen));
                end else begin
                    want = avg_expected.pop_front();
                    if (int'(want.used) > peak_used) peak_used = int'(want.used);
                    if (out_if.average_value !== want.avg)
                        flag_mismatch($sformatf("item %0d average_value got %0d want %0d",
                                                results_seen, out_if.average_value,
                                                want.avg));
                    if (out_if.epochs_used !== want.used)
                        flag_mismatch($sformatf("item %0d epochs_used got %0d want %0d",
                                                results_seen, out_if.epochs_used,
                                                want.used));
                    if (out_if.epoch_end !== want.last)
                        flag_mismatch($sformatf("item %0d epoch_end got %0b want %0b",
                                                results_seen, out_if.epoch_end,
                                                want.last));
                end
            end
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= long_hold_mark) begin
                long_hold_done = 1'b1;
                hold_left    <= LONG_HOLD - 1;
                out_if.ready <= 1'b0;
            end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
                hold_left    <= $urandom_range(0, 9);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata     <= data;
        do @(posedge clk); while (!cfg_if.ready);
        apply_setting(idx, data);
        cfg_if.valid <= 1'b0;
        settings_count++;
    endtask

    task automatic wait_quiet();
        while (pending_samples.size() != 0 || in_if.valid || avg_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_samples(input int count, input sample_mix_t mix);
        repeat (count) pending_samples.push_back(pick_sample(mix));
    endtask

    task automatic queue_list(input logic signed [SAMPLE_W-1:0] vals [$]);
        foreach (vals[i]) pending_samples.push_back(vals[i]);
    endtask

    task automatic run_phase(input int unsigned win, input int unsigned len,
                             input int count, input sample_mix_t mix,
                             input bit mid_pause);
        wait_quiet();
        if ($urandom_range(0, 1)) begin
            write_reg(emavg_pkg::REG_WINDOW_SIZE, CFG_DATA_W'(win));
            write_reg(emavg_pkg::REG_EPOCH_LENGTH, CFG_DATA_W'(len));
        end else begin
            write_reg(emavg_pkg::REG_EPOCH_LENGTH, CFG_DATA_W'(len));
            write_reg(emavg_pkg::REG_WINDOW_SIZE, CFG_DATA_W'(win));
        end
        if (mid_pause) begin
            queue_samples(count / 2, mix);
            wait_quiet();
            queue_samples(count - count / 2, mix);
        end else begin
            queue_samples(count, mix);
        end
    endtask

    initial begin
        in_if.valid         = 1'b0;
        in_if.sample_value  = '0;
        out_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.reg_index    = '0;
        cfg_if.wdata        = '0;
        mismatch_count      = 0;
        results_seen        = 0;
        settings_count      = 0;
        peak_used           = 0;
        in_idle_pct         = 20;
        out_idle_pct        = 20;
        long_hold_mark      = 32'h7FFF_FFFF;
        long_hold_done      = 1'b0;
        window_eff          = emavg_pkg::WINDOW_RESET;
        length_eff          = emavg_pkg::LENGTH_RESET;
        clear_history();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: window of one, long epoch, so the average is the sample
        queue_list('{SAMPLE_MAX, SAMPLE_MIN, 24'sd0, -24'sd1, 24'sd1,
                     24'sh555555, 24'shAAAAAA});
        wait_quiet();

        // zero settings act as one: every item closes an epoch
        write_reg(emavg_pkg::REG_WINDOW_SIZE, '0);
        write_reg(emavg_pkg::REG_EPOCH_LENGTH, '0);
        queue_list('{SAMPLE_MAX, SAMPLE_MIN, -24'sd1});
        wait_quiet();

        // truncation toward zero; unmapped register must leave history alone
        write_reg(emavg_pkg::REG_WINDOW_SIZE, CFG_DATA_W'(3));
        write_reg(emavg_pkg::REG_EPOCH_LENGTH, CFG_DATA_W'(1));
        queue_list('{-24'sd1, -24'sd1, 24'sd0});
        wait_quiet();
        write_reg(REG_UNMAPPED, CFG_DATA_W'(5));
        queue_list('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN});
        wait_quiet();

        // partial epochs over two positions
        write_reg(emavg_pkg::REG_EPOCH_LENGTH, CFG_DATA_W'(2));
        write_reg(emavg_pkg::REG_WINDOW_SIZE, CFG_DATA_W'(2));
        queue_list('{24'sd5, -24'sd7, -24'sd4, 24'sd8, 24'sd3, -24'sd9});

        run_phase(64, 1, 100, MIX_HIGH, 1'b0);
        run_phase(64, 1, 100, MIX_LOW, 1'b0);
        run_phase(127, 8191, 30, MIX_ANY, 1'b0);
        run_phase(5, 3, 150, MIX_ANY, 1'b1);
        wait_quiet();
        long_hold_mark = results_seen + 100;
        run_phase(64, 4, 320, MIX_ANY, 1'b0);
        for (int k = 0; k < 3; k++) begin
            wait_quiet();
            in_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : 25;
            out_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            run_phase($urandom_range(1, 12), $urandom_range(1, 24),
                      230, MIX_ANY, 1'b0);
        end
        wait_quiet();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_phase($urandom_range(2, 9), $urandom_range(2, 11), 200, MIX_ANY, 1'b0);

        while (pending_samples.size() != 0 || in_if.valid) @(posedge clk);
        while (avg_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d averages over %0d register writes; widest average %0d epochs.",
                 results_seen, settings_count, peak_used);
        if (mismatch_count == 0)
            $display("epoch_moving_average_unit verification clean");
        else
            $display("epoch_moving_average_unit verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("Run timed out with %0d averages still pending.", avg_expected.size());
        $display("epoch_moving_average_unit verification failed");
        $finish;
    end

endmodule
